>>> rtl/rtc_cmos_register_interrupt_unit_macros.svh
// assertion macros for the rtc/cmos register and interrupt unit
// used by the port checker; needs nothing else
`ifndef RTC_CMOS_REGISTER_INTERRUPT_UNIT_MACROS_SVH
`define RTC_CMOS_REGISTER_INTERRUPT_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define RTCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, held off during reset
`define RTCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

>>> rtl/rtcc_pkg.sv
// shared types, register indexes and helper functions of the rtc/cmos unit
// no dependencies
`timescale 1ns / 1ps

package rtcc_pkg;

  localparam int STORE_BYTES = 128;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam logic [7:0] IDX_LIMIT = 8'(STORE_BYTES);

  typedef enum logic [2:0] {
    OP_READ      = 3'd0,
    OP_WRITE     = 3'd1,
    OP_BASE_TICK = 3'd2,
    OP_SEC_TICK  = 3'd3,
    OP_UPD_END   = 3'd4
  } rtcc_op_t;

  localparam logic PORT_INDEX = 1'b0;
  localparam logic PORT_DATA  = 1'b1;

  localparam logic [6:0] RG_SEC     = 7'h00;
  localparam logic [6:0] RG_SEC_AL  = 7'h01;
  localparam logic [6:0] RG_MIN     = 7'h02;
  localparam logic [6:0] RG_MIN_AL  = 7'h03;
  localparam logic [6:0] RG_HOUR    = 7'h04;
  localparam logic [6:0] RG_HOUR_AL = 7'h05;
  localparam logic [6:0] RG_A       = 7'h0a;
  localparam logic [6:0] RG_B       = 7'h0b;
  localparam logic [6:0] RG_C       = 7'h0c;
  localparam logic [6:0] RG_D       = 7'h0d;

  localparam logic [7:0] IDX_MASK    = 8'h7f;
  localparam logic [7:0] B_WR_MASK   = 8'hf7;
  localparam logic [7:0] B_SET_MASK  = 8'hef;
  localparam logic [7:0] C_PERIODIC  = 8'hc0;
  localparam logic [7:0] C_UPDATE    = 8'h90;
  localparam logic [7:0] C_ALARM     = 8'ha0;
  localparam logic [7:0] B_RST_MASK  = 8'h8f;
  localparam logic [7:0] BIT7        = 8'h80;

  // period in base ticks for a rate nibble; rates 1 and 2 behave as 8 and 9
  function automatic logic [15:0] divider_period(input logic [3:0] rate);
    logic [3:0] r;
    r = rate;
    if (r == 4'd1 || r == 4'd2) begin
      r = r + 4'd7;
    end
    if (r == 4'd0) begin
      return 16'd0;
    end
    return 16'd1 << (r - 4'd1);
  endfunction

  // alarm byte matches when don't-care or equal to the time byte
  function automatic logic alarm_ok(input logic [7:0] t, input logic [7:0] al);
    return (al[7:6] == 2'b11) || (t == al);
  endfunction

endpackage

>>> rtl/rtcc_store.sv
// general byte store of the rtc/cmos unit: one write port, one registered read
// port with write forwarding, per-entry valid bits standing for the zero image
// depends on rtcc_pkg
`timescale 1ns / 1ps

module rtcc_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [rtcc_pkg::ADDR_W-1:0] wr_addr,
  input  logic [7:0]                wr_data,
  input  logic [rtcc_pkg::ADDR_W-1:0] rd_addr,
  output logic [7:0]                rd_data
);
  import rtcc_pkg::*;

  logic [7:0]             mem [STORE_BYTES];
  logic [STORE_BYTES-1:0] valid_r;
  logic [7:0]             rd_data_r;
  logic                   rd_vld_r;
  logic                   fwd;

  assign fwd = wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= fwd ? wr_data : mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= fwd || valid_r[rd_addr];
    end
  end

  // an entry never written reads as zero
  assign rd_data = rd_vld_r ? rd_data_r : 8'h00;

endmodule

>>> rtl/rtc_cmos_register_interrupt_unit.sv
// top level of the rtc/cmos register and interrupt unit
// an accepted item's result is on the output register in the next cycle
// throughput: one item per cycle while out_tready is high; in_tready stays high while the result slot drains
// reset: synchronous active-low rst_n clears time, alarm and control registers, index and
// divider count, and marks the whole general store as reading zero at once
// depends on rtcc_pkg and rtcc_store
`timescale 1ns / 1ps

module rtc_cmos_register_interrupt_unit (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [2:0] op, [3] port, [11:4] wdata, [15:12] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  // out_tdata: [7:0] rdata, [8] irq, [15:9] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata
);
  import rtcc_pkg::*;

  // item fields
  logic [2:0] in_op;
  logic       in_port;
  logic [7:0] in_wdata;
  logic       accept;

  // time, alarm and control registers kept in flops; D always reads zero
  logic [7:0] sec_r, sec_nxt, sec_al_r, sec_al_nxt;
  logic [7:0] min_r, min_nxt, min_al_r, min_al_nxt;
  logic [7:0] hour_r, hour_nxt, hour_al_r, hour_al_nxt;
  logic [7:0] reg_a_r, reg_a_nxt, reg_b_r, reg_b_nxt, reg_c_r, reg_c_nxt;
  logic [6:0]  index_r, index_nxt;
  logic [14:0] count_r, count_nxt;

  // result register
  logic       out_vld_r, out_vld_nxt;
  logic [7:0] out_rdata_r, out_rdata_nxt;
  logic       out_irq_r, out_irq_nxt;

  // general store
  logic       st_wr_en;
  logic [7:0] st_rd_data;

  // helpers
  logic       idx_out;
  logic       idx_special;
  logic [7:0] cur_byte;
  logic [7:0] b_wr;
  logic       running;
  logic [15:0] count_inc;
  logic       alarm_hit;

  assign in_op    = in_tdata[2:0];
  assign in_port  = in_tdata[3];
  assign in_wdata = in_tdata[11:4];

  // result slot is free or drains this cycle
  assign in_tready = !out_vld_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign idx_out = ({1'b0, index_r} >= IDX_LIMIT);

  // indexes that live in flops rather than in the store
  always_comb begin
    case (index_r)
      RG_SEC, RG_SEC_AL, RG_MIN, RG_MIN_AL, RG_HOUR, RG_HOUR_AL,
      RG_A, RG_B, RG_C, RG_D: idx_special = 1'b1;
      default:                idx_special = 1'b0;
    endcase
  end

  // byte currently addressed by the index
  always_comb begin
    case (index_r)
      RG_SEC:     cur_byte = sec_r;
      RG_SEC_AL:  cur_byte = sec_al_r;
      RG_MIN:     cur_byte = min_r;
      RG_MIN_AL:  cur_byte = min_al_r;
      RG_HOUR:    cur_byte = hour_r;
      RG_HOUR_AL: cur_byte = hour_al_r;
      RG_A:       cur_byte = reg_a_r;
      RG_B:       cur_byte = reg_b_r;
      RG_C:       cur_byte = reg_c_r;
      RG_D:       cur_byte = 8'h00;
      default:    cur_byte = st_rd_data;
    endcase
  end

  // B write rule: bit 3 always clear, bit 4 cleared while set mode is requested
  always_comb begin
    b_wr = in_wdata & B_WR_MASK;
    if ((b_wr & BIT7) != 8'h00) begin
      b_wr = b_wr & B_SET_MASK;
    end
  end

  // periodic divider runs with PIE set, a rate selected and the divider chain on
  assign running   = reg_b_r[6] && (reg_a_r[3:0] != 4'd0) && (reg_a_r[6:5] != 2'b00);
  assign count_inc = {1'b0, count_r} + 16'd1;

  assign alarm_hit = reg_b_r[5] && alarm_ok(sec_r, sec_al_r) &&
                     alarm_ok(min_r, min_al_r) && alarm_ok(hour_r, hour_al_r);

  // single-pass item processing
  always_comb begin
    sec_nxt     = sec_r;
    sec_al_nxt  = sec_al_r;
    min_nxt     = min_r;
    min_al_nxt  = min_al_r;
    hour_nxt    = hour_r;
    hour_al_nxt = hour_al_r;
    reg_a_nxt   = reg_a_r;
    reg_b_nxt   = reg_b_r;
    reg_c_nxt   = reg_c_r;
    index_nxt   = index_r;
    count_nxt   = count_r;
    st_wr_en    = 1'b0;
    out_rdata_nxt = 8'h00;

    if (accept) begin
      case (in_op)
        OP_READ: begin
          if (in_port == PORT_INDEX || idx_out) begin
            out_rdata_nxt = 8'hff;
          end else begin
            out_rdata_nxt = cur_byte;
            // reading C acknowledges every flag
            if (index_r == RG_C) begin
              reg_c_nxt = 8'h00;
            end
          end
        end
        OP_WRITE: begin
          if (in_port == PORT_INDEX) begin
            index_nxt = 7'(in_wdata & IDX_MASK);
          end else if (!idx_out) begin
            case (index_r)
              RG_SEC:     sec_nxt     = in_wdata;
              RG_SEC_AL:  sec_al_nxt  = in_wdata;
              RG_MIN:     min_nxt     = in_wdata;
              RG_MIN_AL:  min_al_nxt  = in_wdata;
              RG_HOUR:    hour_nxt    = in_wdata;
              RG_HOUR_AL: hour_al_nxt = in_wdata;
              RG_A: begin
                // update-in-progress bit is owned by the tick logic
                reg_a_nxt = (reg_a_r & BIT7) | (in_wdata & IDX_MASK);
                count_nxt = '0;
              end
              RG_B: begin
                reg_b_nxt = b_wr;
                if (!reg_b_r[6] && b_wr[6]) begin
                  count_nxt = '0;
                end
              end
              RG_C, RG_D: begin
                // read-only status registers
              end
              default: st_wr_en = 1'b1;
            endcase
          end
        end
        OP_BASE_TICK: begin
          if (!running) begin
            count_nxt = '0;
          end else if (count_inc >= divider_period(reg_a_r[3:0])) begin
            count_nxt = '0;
            reg_c_nxt = reg_c_r | C_PERIODIC;
          end else begin
            count_nxt = count_inc[14:0];
          end
        end
        OP_SEC_TICK: begin
          // no update cycle while the divider is held in reset or in set mode
          if (reg_a_r[6:5] != 2'b11 && !reg_b_r[7]) begin
            reg_a_nxt = reg_a_r | BIT7;
          end
        end
        OP_UPD_END: begin
          if (reg_b_r[4]) begin
            reg_c_nxt = reg_c_nxt | C_UPDATE;
          end
          if (alarm_hit) begin
            reg_c_nxt = reg_c_nxt | C_ALARM;
          end
          reg_a_nxt = reg_a_r & IDX_MASK;
        end
        default: begin
          // unknown codes leave the state alone
        end
      endcase
    end
  end

  assign out_irq_nxt = reg_c_nxt[7];
  assign out_vld_nxt = accept || (out_vld_r && !out_tready);

  // the next index steers the registered store read, so its byte is ready once that index is held
  rtcc_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (st_wr_en && !idx_special),
    .wr_addr (index_r[ADDR_W-1:0]),
    .wr_data (in_wdata),
    .rd_addr (index_nxt[ADDR_W-1:0]),
    .rd_data (st_rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r     <= 8'h00;
      sec_al_r  <= 8'h00;
      min_r     <= 8'h00;
      min_al_r  <= 8'h00;
      hour_r    <= 8'h00;
      hour_al_r <= 8'h00;
      reg_a_r   <= 8'h00;
      reg_b_r   <= 8'h00 & B_RST_MASK;
      reg_c_r   <= 8'h00;
      index_r   <= '0;
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      sec_r     <= sec_nxt;
      sec_al_r  <= sec_al_nxt;
      min_r     <= min_nxt;
      min_al_r  <= min_al_nxt;
      hour_r    <= hour_nxt;
      hour_al_r <= hour_al_nxt;
      reg_a_r   <= reg_a_nxt;
      reg_b_r   <= reg_b_nxt;
      reg_c_r   <= reg_c_nxt;
      index_r   <= index_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // result payload, loaded only when an item is taken
  always_ff @(posedge clk) begin
    if (accept) begin
      out_rdata_r <= out_rdata_nxt;
      out_irq_r   <= out_irq_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'b0, out_irq_r, out_rdata_r};

endmodule

>>> rtl/rtcc_checker.sv
// port-level checker for the rtc/cmos unit, bound onto the top level
// depends on rtcc_pkg and rtc_cmos_register_interrupt_unit_macros.svh
`timescale 1ns / 1ps
`include "rtc_cmos_register_interrupt_unit_macros.svh"

module rtcc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);
  import rtcc_pkg::*;

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  `RTCC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `RTCC_ASSERT_NOW(a_ready_when_free, clk, rst_n, !out_tvalid, in_tready)
  `RTCC_ASSERT_NEXT(a_result_follows, clk, rst_n, in_acc, out_tvalid)
  `RTCC_ASSERT_NEXT(a_index_read_ff, clk, rst_n, in_acc && in_tdata[2:0] == OP_READ && in_tdata[3] == PORT_INDEX, out_tdata[7:0] == 8'hff)
  `RTCC_ASSERT_NEXT(a_nonread_zero, clk, rst_n, in_acc && in_tdata[2:0] != OP_READ, out_tdata[7:0] == 8'h00)

endmodule

bind rtc_cmos_register_interrupt_unit rtcc_checker u_rtcc_checker (.*);
